// File: rtl/core/mavg_pkg.sv
// Package for the moving-average filter: default sizes and the sequencer states.
// No dependencies; imported by moving_average_filter.
package mavg_pkg;

  localparam int unsigned MAX_WINDOW_DEF   = 64;
  localparam int unsigned SAMPLE_WIDTH_DEF = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_DONE
  } mavg_state_e;

endpackage

// File: rtl/core/moving_average_filter.sv
// Boxcar moving-average filter: delay-line memory, sequential summing and a
// one-bit-per-cycle restoring divider. Depends on mavg_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries sample_i and series_start_i;
//   series_start_i opens a new series. Output channel (out_valid_o / out_ready_i)
//   carries average_o, the truncated mean of the last window_length samples.
//   A series that has not yet reached the window length gives no result.
//   window_length_we_i / window_length_i write the window; zero is ignored and
//   values above MAX_WINDOW saturate. Write it only while the block is idle.
// Sequence:
//   A request that gives no result is done in ST_IDLE alone. Otherwise the block
//   reads the window from the delay-line memory, one entry per cycle through
//   its single registered read port, then the divider produces one quotient
//   bit per cycle, and ST_DONE hands the result to the output register.
//   One request is processed at a time.
// Reset and stall:
//   Reset clears the window to 1, fill count and write pointer to zero; the
//   history memory is not cleared. The output register holds a finished result
//   while the receiver stalls; the next request is still taken and processed,
//   and waits at the end until the output register is free.
module moving_average_filter
  import mavg_pkg::*;
#(
  parameter int unsigned MAX_WINDOW   = MAX_WINDOW_DEF,
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  localparam int unsigned WIN_W = $clog2(MAX_WINDOW + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           window_length_we_i,
  input  logic        [WIN_W-1:0]        window_length_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  logic                           series_start_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0] average_o
);

  localparam int unsigned PTR_W = $clog2(MAX_WINDOW);
  localparam int unsigned SUM_W = SAMPLE_WIDTH + $clog2(MAX_WINDOW);
  localparam int unsigned BIT_W = $clog2(SUM_W + 1);
  localparam logic [PTR_W-1:0] PtrLast = PTR_W'(MAX_WINDOW - 1);
  localparam logic [WIN_W-1:0] WinMax  = WIN_W'(MAX_WINDOW);

  mavg_state_e state_q, state_d;

  logic [WIN_W-1:0]        win_q;
  logic [WIN_W-1:0]        fill_q, fill_d;
  logic [PTR_W-1:0]        wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]        rd_ptr_q, rd_ptr_d;
  logic [WIN_W-1:0]        rd_cnt_q, rd_cnt_d;
  logic                    rd_vld_q, rd_vld_d;
  logic [SUM_W-1:0]        acc_q, acc_d;
  logic [SUM_W-1:0]        dvd_q, dvd_d;
  logic [WIN_W-1:0]        rem_q, rem_d;
  logic                    neg_q, neg_d;
  logic [BIT_W-1:0]        bit_cnt_q, bit_cnt_d;
  logic                    out_valid_q, out_valid_d;
  logic [SAMPLE_WIDTH-1:0] average_q, average_d;

  logic [SAMPLE_WIDTH-1:0] hist_mem [MAX_WINDOW];
  logic [SAMPLE_WIDTH-1:0] rd_data_q;
  logic                    wr_en, rd_en;

  logic                    in_fire;
  logic [WIN_W-1:0]        fill_next;
  logic [WIN_W:0]          trial;
  logic [SUM_W-1:0]        quot_signed;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign average_o   = average_q;

  // fill count after taking in the current request
  always_comb begin
    if (series_start_i) begin
      fill_next = WIN_W'(1);
    end else if (fill_q < WinMax) begin
      fill_next = fill_q + WIN_W'(1);
    end else begin
      fill_next = fill_q;
    end
  end

  assign trial       = {rem_q, dvd_q[SUM_W-1]};
  assign quot_signed = neg_q ? (~dvd_q + SUM_W'(1)) : dvd_q;

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    wr_ptr_d    = wr_ptr_q;
    rd_ptr_d    = rd_ptr_q;
    rd_cnt_d    = rd_cnt_q;
    rd_vld_d    = 1'b0;
    acc_d       = acc_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    neg_d       = neg_q;
    bit_cnt_d   = bit_cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    average_d   = average_q;
    wr_en       = 1'b0;
    rd_en       = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          wr_en    = 1'b1;
          wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PTR_W'(1);
          fill_d   = fill_next;
          if (fill_next >= win_q) begin
            rd_ptr_d = wr_ptr_q;
            rd_cnt_d = win_q;
            acc_d    = '0;
            state_d  = ST_SUM;
          end
        end
      end

      ST_SUM: begin
        // newest entry first, walking back through the ring
        if (rd_cnt_q != '0) begin
          rd_en    = 1'b1;
          rd_vld_d = 1'b1;
          rd_cnt_d = rd_cnt_q - WIN_W'(1);
          rd_ptr_d = (rd_ptr_q == '0) ? PtrLast : rd_ptr_q - PTR_W'(1);
        end
        if (rd_vld_q) begin
          acc_d = acc_q + {{(SUM_W - SAMPLE_WIDTH){rd_data_q[SAMPLE_WIDTH-1]}}, rd_data_q};
        end else if (rd_cnt_q == '0) begin
          neg_d     = acc_q[SUM_W-1];
          dvd_d     = acc_q[SUM_W-1] ? (~acc_q + SUM_W'(1)) : acc_q;
          rem_d     = '0;
          bit_cnt_d = BIT_W'(SUM_W);
          state_d   = ST_DIV;
        end
      end

      ST_DIV: begin
        // restoring division of the magnitude, quotient bits shift in at the bottom
        if (trial >= {1'b0, win_q}) begin
          rem_d = WIN_W'(trial - {1'b0, win_q});
          dvd_d = {dvd_q[SUM_W-2:0], 1'b1};
        end else begin
          rem_d = trial[WIN_W-1:0];
          dvd_d = {dvd_q[SUM_W-2:0], 1'b0};
        end
        bit_cnt_d = bit_cnt_q - BIT_W'(1);
        if (bit_cnt_q == BIT_W'(1)) begin
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          average_d   = quot_signed[SAMPLE_WIDTH-1:0];
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      win_q       <= WIN_W'(1);
      fill_q      <= '0;
      wr_ptr_q    <= '0;
      rd_cnt_q    <= '0;
      rd_vld_q    <= 1'b0;
      bit_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      wr_ptr_q    <= wr_ptr_d;
      rd_cnt_q    <= rd_cnt_d;
      rd_vld_q    <= rd_vld_d;
      bit_cnt_q   <= bit_cnt_d;
      out_valid_q <= out_valid_d;
      if (window_length_we_i && (window_length_i != '0)) begin
        win_q <= (window_length_i > WinMax) ? WinMax : window_length_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_ptr_q  <= rd_ptr_d;
    acc_q     <= acc_d;
    dvd_q     <= dvd_d;
    rem_q     <= rem_d;
    neg_q     <= neg_d;
    average_q <= average_d;
  end

  // delay-line memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      hist_mem[wr_ptr_q] <= sample_i;
    end
    if (rd_en) begin
      rd_data_q <= hist_mem[rd_ptr_q];
    end
  end

endmodule

// File: bench/tb_top.sv
// Self-checking bench for moving_average_filter: random and directed sample
// series, a scoreboard of predicted averages, randomized flow control.
// Depends on mavg_pkg and the moving_average_filter RTL.
module tb_top
  import mavg_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_W       = MAX_WINDOW_DEF;
  localparam int SW          = SAMPLE_WIDTH_DEF;
  localparam int WIN_W       = $clog2(MAX_WINDOW_DEF + 1);
  localparam int SETTLE_CYC  = 100;      // > window + divider + handoff
  localparam int LONG_STALL  = 600;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [SW-1:0] smp;
    logic                 start;
  } sample_req_t;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  logic                 win_we   = 1'b0;
  logic [WIN_W-1:0]     win_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic signed [SW-1:0] smp_d    = '0;
  logic                 start_d  = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [SW-1:0] average;

  sample_req_t          pend_q[$];
  logic signed [SW-1:0] avg_exp_q[$];

  // filter mirror
  logic signed [SW-1:0] hist_m [MAX_W];
  int wpos_m = 0;
  int fill_m = 0;
  int win_m  = 1;

  int tx_idle_pct = 9;
  int rx_idle_pct = 47;
  int stall_req   = 0;
  int stall_seen  = 0;
  int stall_left  = 0;
  int err_cnt     = 0;
  int unsigned cycle_cnt = 0;

  always #5 clk_i = ~clk_i;

  moving_average_filter u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_n),
    .window_length_we_i (win_we),
    .window_length_i    (win_data),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .sample_i           (smp_d),
    .series_start_i     (start_d),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .average_o          (average)
  );

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $time);
    err_cnt++;
  endtask

  function automatic void predict_average(input logic signed [SW-1:0] s, input logic st);
    longint acc;
    int     idx;
    if (st) begin
      fill_m = 0;
    end
    hist_m[wpos_m] = s;
    wpos_m = (wpos_m + 1) % MAX_W;
    if (fill_m < MAX_W) begin
      fill_m++;
    end
    if (fill_m < win_m) begin
      return;
    end
    acc = 0;
    for (int k = 0; k < win_m; k++) begin
      idx = (wpos_m + MAX_W - 1 - k) % MAX_W;
      acc += hist_m[idx];
    end
    // signed division truncates toward zero
    avg_exp_q.push_back(SW'(acc / longint'(win_m)));
  endfunction

  // sender
  always @(posedge clk_i) begin : drive_proc
    logic fire;
    fire = in_valid && (in_ready === 1'b1);
    if (fire) begin
      predict_average(smp_d, start_d);
    end
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !fire) begin
      in_valid <= 1'b1;
    end else if (pend_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
      in_valid <= 1'b1;
      smp_d    <= pend_q[0].smp;
      start_d  <= pend_q[0].start;
      void'(pend_q.pop_front());
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver and scoreboard
  always @(posedge clk_i) begin : recv_proc
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (avg_exp_q.size() == 0) begin
        report_mismatch("average with no request pending", average, 0);
      end else begin
        if (average !== avg_exp_q[0]) begin
          report_mismatch("average", average, avg_exp_q[0]);
        end
        void'(avg_exp_q.pop_front());
      end
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (stall_req != stall_seen) begin
        stall_seen = stall_req;
        stall_left = LONG_STALL;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  task automatic push_req(input logic signed [SW-1:0] s, input logic st);
    sample_req_t r;
    r.smp   = s;
    r.start = st;
    pend_q.push_back(r);
  endtask

  // wait until every request is taken and answered, then let the block go idle
  task automatic settle();
    while (pend_q.size() != 0 || in_valid || avg_exp_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_window(input logic [WIN_W-1:0] v);
    @(posedge clk_i);
    win_we   <= 1'b1;
    win_data <= v;
    @(posedge clk_i);
    win_we <= 1'b0;
    // zero is dropped, oversize clamps
    if (v != 0) begin
      win_m = (v > MAX_W) ? MAX_W : int'(v);
    end
  endtask

  function automatic logic signed [SW-1:0] pick_sample(input int mode, input int k);
    logic signed [SW-1:0] s;
    case (mode)
      0:       s = SW'($urandom);
      1:       s = 16'sh7fff;
      2:       s = 16'sh8000;
      3:       s = SW'(int'($urandom_range(8)) - 4);
      default: s = k[0] ? 16'sh7fff : 16'sh8000;
    endcase
    if ($urandom_range(19) == 0) begin
      s = SW'($urandom);
    end
    return s;
  endfunction

  // mostly full series past the window, some short ones and short noise bursts
  task automatic queue_series_mix(input int n_items);
    int left, len, mode, r;
    left = n_items;
    while (left > 0) begin
      r = $urandom_range(99);
      if (r < 70) begin
        len = win_m + $urandom_range(12);
      end else if (r < 85) begin
        len = $urandom_range(win_m, 1);
      end else begin
        len = $urandom_range(3, 1);
      end
      mode = $urandom_range(4);
      for (int k = 0; k < len; k++) begin
        push_req(pick_sample(mode, k), (k == 0) && ($urandom_range(9) != 0));
      end
      left -= len;
    end
  endtask

  task automatic run_segment(input logic [WIN_W-1:0] wcfg, input int n_items);
    settle();
    write_window(wcfg);
    @(negedge clk_i);
    queue_series_mix(n_items);
  endtask

  initial begin : main_proc
    int waited;
    repeat (8) @(posedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    // window 1 after reset; first request has no series flag
    push_req(16'sh7fff, 1'b0);
    push_req(16'sh8000, 1'b0);
    push_req(-16'sd1, 1'b1);
    push_req(16'sd0, 1'b0);
    push_req(16'sd1, 1'b0);

    settle();
    write_window(7'd3);
    write_window(7'd0);        // dropped, window stays 3
    @(negedge clk_i);
    push_req(-16'sd1, 1'b1);
    push_req(-16'sd1, 1'b0);
    push_req(-16'sd1, 1'b0);
    push_req(16'sd1, 1'b0);    // -1/3 truncates to 0
    push_req(16'sd2, 1'b0);
    push_req(16'sh8000, 1'b1); // series too short for any result
    push_req(16'sd5, 1'b1);
    push_req(16'sd6, 1'b0);
    push_req(16'sd8, 1'b0);

    // shrink window mid-series
    settle();
    write_window(7'd2);
    @(negedge clk_i);
    push_req(16'sh7fff, 1'b0);
    push_req(16'sh7fff, 1'b0);
    push_req(16'sh8000, 1'b1);
    push_req(-16'sd32767, 1'b0);

    // receiver stalling a little under half the time
    run_segment(7'd4, 40);
    run_segment(7'd127, 40);   // clamps to max window

    settle();
    @(negedge clk_i);
    tx_idle_pct = 47;
    rx_idle_pct = 9;
    run_segment(7'd0, 10);
    run_segment(7'd1, 30);
    run_segment(WIN_W'($urandom_range(16, 2)), 30);

    settle();
    @(negedge clk_i);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_segment(7'd64, 60);
    stall_req++;               // long hold-off while requests keep coming
    run_segment(WIN_W'($urandom_range(126, 65)), 10);
    run_segment(7'd2, 30);
    run_segment(WIN_W'($urandom_range(MAX_W, 1)), 20);

    while (pend_q.size() != 0 || in_valid) begin
      @(posedge clk_i);
    end
    waited = 0;
    while (avg_exp_q.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (avg_exp_q.size() != 0) begin
      report_mismatch("averages never delivered", 0, avg_exp_q.size());
    end

    if (err_cnt == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
